// ----- rtl/core/pffm_pkg.sv -----
package pffm_pkg;

  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned PAGE_W    = 6;
  // Owner entries hold a page index plus an empty flag in the top bit.
  localparam int unsigned OWN_W     = PAGE_W + 1;

  localparam logic [CFG_W-1:0] PAGES_RST  = 7'd64;
  localparam logic [CFG_W-1:0] FRAMES_RST = 7'd16;
  localparam logic [OWN_W-1:0] OWNER_EMPTY = {1'b1, {PAGE_W{1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAGES_IN_USE  = 1'b0,
    REG_FRAMES_IN_USE = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    LOC_NONE = 2'd0,
    LOC_RAM  = 2'd1,
    LOC_SWAP = 2'd2
  } loc_e;

  typedef enum logic [1:0] {
    ACC_NONE = 2'd0,
    ACC_READ = 2'd1,
    ACC_RW   = 2'd2
  } prot_e;

  typedef struct packed {
    loc_e  loc;
    prot_e prot;
    logic  dirty;
    logic  evac;
  } pte_t;

  typedef struct packed {
    status_e             status;
    logic                evicted;
    logic [PAGE_W-1:0]   victim;
    logic [PAGE_W-1:0]   slot;
    logic                wb;
    logic                mapped;
    logic [PAGE_W-1:0]   frame;
    prot_e               prot;
  } res_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_res_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PCHK,
    S_FSCAN,
    S_SSCAN,
    S_V0,
    S_V1,
    S_V2,
    S_V3,
    S_DONE
  } state_e;

endpackage

// ----- rtl/core/pffm_ram.sv -----
module pffm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/pffm_scan.sv -----
module pffm_scan #(
  parameter int unsigned CNT_W = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [CNT_W-1:0]      limit_i,
  input  logic                  empty_i,
  output logic [CNT_W-1:0]      addr_o,
  output logic [CNT_W-1:0]      index_o,
  output pffm_pkg::scan_res_t   res_o
);
  import pffm_pkg::*;

  logic             busy_q, busy_d;
  logic             chk_q, chk_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] chk_idx_q, chk_idx_d;
  logic [CNT_W-1:0] lim_q, lim_d;

  // One entry is issued per cycle; its empty flag is checked in the next cycle,
  // when the registered read data arrives.
  always_comb begin
    busy_d    = busy_q;
    chk_d     = 1'b0;
    idx_d     = idx_q;
    chk_idx_d = chk_idx_q;
    lim_d     = lim_q;
    res_o     = '0;

    if (busy_q && (idx_q < lim_q)) begin
      chk_d     = 1'b1;
      chk_idx_d = idx_q;
      idx_d     = idx_q + CNT_W'(1);
    end

    if (chk_q) begin
      if (empty_i) begin
        res_o.done  = 1'b1;
        res_o.found = 1'b1;
      end else if ((chk_idx_q + CNT_W'(1)) == lim_q) begin
        res_o.done = 1'b1;
      end
    end

    if (res_o.done) begin
      busy_d = 1'b0;
      chk_d  = 1'b0;
    end

    if (start_i) begin
      busy_d = 1'b1;
      chk_d  = 1'b0;
      idx_d  = '0;
      lim_d  = limit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      chk_q  <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      chk_q  <= chk_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
    lim_q     <= lim_d;
  end

  assign addr_o  = idx_q;
  assign index_o = chk_idx_q;

endmodule

// ----- rtl/core/page_fault_frame_manager.sv -----
// Page fault frame manager.
// The input channel (in_valid_i, in_stall_o, fault_page_i) takes one fault per
// item; the output channel (out_valid_o, out_stall_i and the result fields)
// returns exactly one result item for it. Page, frame and swap owner tables
// sit in single-port-read RAMs; one scanner walks the frame table and then the
// swap table, one entry per cycle, looking for the first empty owner.
// An out-of-range page goes straight to the result; an already mapped page
// needs only the page table read. Else a scan of the nf frames in use seeks
// a free frame; if none is free, a scan of the np pages in use seeks a free
// swap slot, and frame 0 is evicted into it, or the item ends as full.
// The input stalls while an item is in work; the next item is taken as soon
// as the result sits in the output register, even if it is not yet taken.
// A stalled result holds; a finished item waits until the output is free.
// After reset the tables are cleared by a pass over max(MAX_PAGES, MAX_FRAMES)
// addresses, during which no item is accepted. Configuration writes (cfg_we_i,
// cfg_idx_i, cfg_data_i) may come at any time the block is idle.
module page_fault_frame_manager #(
  parameter int unsigned MAX_PAGES  = 64,
  parameter int unsigned MAX_FRAMES = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pffm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pffm_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [pffm_pkg::PAGE_W-1:0]     fault_page_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic                            evicted_o,
  output logic [pffm_pkg::PAGE_W-1:0]     victim_page_o,
  output logic [pffm_pkg::PAGE_W-1:0]     swap_slot_o,
  output logic                            write_back_o,
  output logic                            mapped_in_o,
  output logic [pffm_pkg::PAGE_W-1:0]     frame_o,
  output logic [1:0]                      new_protection_o
);
  import pffm_pkg::*;

  localparam int unsigned MAX_DEPTH = (MAX_PAGES > MAX_FRAMES) ? MAX_PAGES : MAX_FRAMES;
  localparam int unsigned CNT_W     = $clog2(MAX_DEPTH + 1);
  localparam int unsigned PA_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned FA_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned PTE_W     = $bits(pte_t);

  state_e state_q, state_d;

  logic [CFG_W-1:0]  pages_q, frames_q;
  logic [CNT_W-1:0]  np, nf;
  logic [CNT_W-1:0]  clr_q, clr_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [PAGE_W-1:0] v_q, v_d;
  logic [CNT_W-1:0]  k_q, k_d;
  pte_t              pte_q, pte_d;
  res_t              res_q, res_d;
  res_t              out_q;
  logic              out_valid_q, out_valid_d;
  logic              out_load;

  logic              pt_we;
  logic [PA_W-1:0]   pt_waddr, pt_raddr;
  pte_t              pt_wdata, pt_rpte;
  logic [PTE_W-1:0]  pt_rdata;

  logic              fr_we;
  logic [FA_W-1:0]   fr_waddr, fr_raddr;
  logic [OWN_W-1:0]  fr_wdata, fr_rdata;

  logic              sw_we;
  logic [PA_W-1:0]   sw_waddr, sw_raddr;
  logic [OWN_W-1:0]  sw_wdata, sw_rdata;

  logic              scan_start;
  logic [CNT_W-1:0]  scan_lim;
  logic              scan_empty;
  logic [CNT_W-1:0]  scan_addr, scan_idx;
  scan_res_t         scan_res;

  pte_t              upd_pte;

  always_comb begin
    if (int'(pages_q) > int'(MAX_PAGES)) begin
      np = CNT_W'(MAX_PAGES);
    end else begin
      np = CNT_W'(pages_q);
    end
    if (int'(frames_q) > int'(MAX_FRAMES)) begin
      nf = CNT_W'(MAX_FRAMES);
    end else if (frames_q == '0) begin
      nf = CNT_W'(1);
    end else begin
      nf = CNT_W'(frames_q);
    end
  end

  pffm_ram #(.WIDTH(PTE_W), .DEPTH(MAX_PAGES)) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  pffm_ram #(.WIDTH(OWN_W), .DEPTH(MAX_FRAMES)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  pffm_ram #(.WIDTH(OWN_W), .DEPTH(MAX_PAGES)) u_swap_ram (
    .clk_i   (clk_i),
    .we_i    (sw_we),
    .waddr_i (sw_waddr),
    .wdata_i (sw_wdata),
    .raddr_i (sw_raddr),
    .rdata_o (sw_rdata)
  );

  pffm_scan #(.CNT_W(CNT_W)) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .limit_i (scan_lim),
    .empty_i (scan_empty),
    .addr_o  (scan_addr),
    .index_o (scan_idx),
    .res_o   (scan_res)
  );

  assign pt_rpte    = pte_t'(pt_rdata);
  assign scan_empty = (state_q == S_SSCAN) ? sw_rdata[PAGE_W] : fr_rdata[PAGE_W];
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Protection raise for a page that is already present.
  always_comb begin
    upd_pte = pt_rpte;
    case (pt_rpte.prot)
      ACC_NONE: upd_pte.prot = ACC_READ;
      ACC_READ: begin
        upd_pte.prot  = ACC_RW;
        upd_pte.dirty = 1'b1;
      end
      default: upd_pte.prot = pt_rpte.prot;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    page_d     = page_q;
    v_d        = v_q;
    k_d        = k_q;
    pte_d      = pte_q;
    res_d      = res_q;
    scan_start = 1'b0;
    scan_lim   = nf;

    pt_we      = 1'b0;
    pt_waddr   = PA_W'(page_q);
    pt_wdata   = '0;
    pt_raddr   = PA_W'(page_q);
    fr_we      = 1'b0;
    fr_waddr   = FA_W'(scan_idx);
    fr_wdata   = {1'b0, page_q};
    fr_raddr   = FA_W'(scan_addr);
    sw_we      = 1'b0;
    sw_waddr   = PA_W'(k_q);
    sw_wdata   = {1'b0, v_q};
    sw_raddr   = PA_W'(scan_addr);

    unique case (state_q)
      S_CLEAR: begin
        pt_we    = (int'(clr_q) < int'(MAX_PAGES));
        pt_waddr = PA_W'(clr_q);
        pt_wdata = '0;
        sw_we    = (int'(clr_q) < int'(MAX_PAGES));
        sw_waddr = PA_W'(clr_q);
        sw_wdata = OWNER_EMPTY;
        fr_we    = (int'(clr_q) < int'(MAX_FRAMES));
        fr_waddr = FA_W'(clr_q);
        fr_wdata = OWNER_EMPTY;
        clr_d    = clr_q + CNT_W'(1);
        if (clr_q == CNT_W'(MAX_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        pt_raddr = PA_W'(fault_page_i);
        if (in_valid_i) begin
          page_d = fault_page_i;
          res_d  = '0;
          if (int'(fault_page_i) >= int'(np)) begin
            res_d.status = ST_RANGE;
            state_d      = S_DONE;
          end else begin
            state_d = S_PCHK;
          end
        end
      end
      S_PCHK: begin
        pte_d = pt_rpte;
        if (pt_rpte.loc == LOC_NONE) begin
          scan_start = 1'b1;
          scan_lim   = nf;
          state_d    = S_FSCAN;
        end else begin
          pt_we      = 1'b1;
          pt_wdata   = upd_pte;
          res_d.prot = upd_pte.prot;
          state_d    = S_DONE;
        end
      end
      S_FSCAN: begin
        if (scan_res.done) begin
          if (scan_res.found) begin
            fr_we          = 1'b1;
            fr_waddr       = FA_W'(scan_idx);
            pt_we          = 1'b1;
            pt_wdata       = '{loc: LOC_RAM, prot: ACC_READ, dirty: pte_q.dirty,
                               evac: pte_q.evac};
            res_d.mapped   = 1'b1;
            res_d.frame    = PAGE_W'(scan_idx);
            res_d.prot     = ACC_READ;
            state_d        = S_DONE;
          end else begin
            scan_start = 1'b1;
            scan_lim   = np;
            state_d    = S_SSCAN;
          end
        end
      end
      S_SSCAN: begin
        scan_lim = np;
        if (scan_res.done) begin
          if (scan_res.found) begin
            k_d           = scan_idx;
            res_d.evicted = 1'b1;
            res_d.slot    = PAGE_W'(scan_idx);
            state_d       = S_V0;
          end else begin
            res_d.status = ST_FULL;
            res_d.prot   = pte_q.prot;
            state_d      = S_DONE;
          end
        end
      end
      S_V0: begin
        fr_raddr = '0;
        state_d  = S_V1;
      end
      S_V1: begin
        v_d      = fr_rdata[PAGE_W-1:0];
        pt_raddr = PA_W'(fr_rdata[PAGE_W-1:0]);
        state_d  = S_V2;
      end
      S_V2: begin
        // Victim goes to swap; frame 0 is handed to the faulting page.
        res_d.victim = v_q;
        res_d.wb     = pt_rpte.dirty | ~pt_rpte.evac;
        pt_we        = 1'b1;
        pt_waddr     = PA_W'(v_q);
        pt_wdata     = '{loc: LOC_SWAP, prot: ACC_NONE, dirty: pt_rpte.dirty, evac: 1'b1};
        sw_we        = 1'b1;
        fr_we        = 1'b1;
        fr_waddr     = '0;
        state_d      = S_V3;
      end
      S_V3: begin
        pt_we        = 1'b1;
        pt_wdata     = '{loc: LOC_RAM, prot: ACC_READ, dirty: pte_q.dirty,
                         evac: pte_q.evac};
        res_d.mapped = 1'b1;
        res_d.frame  = '0;
        res_d.prot   = ACC_READ;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = (out_valid_q & out_stall_i) | out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      pages_q     <= PAGES_RST;
      frames_q    <= FRAMES_RST;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_PAGES_IN_USE) begin
          pages_q <= cfg_data_i;
        end else if (cfg_idx_i == REG_FRAMES_IN_USE) begin
          frames_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    page_d_reg: begin
      page_q <= page_d;
    end
    v_q   <= v_d;
    k_q   <= k_d;
    pte_q <= pte_d;
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign evicted_o        = out_q.evicted;
  assign victim_page_o    = out_q.victim;
  assign swap_slot_o      = out_q.slot;
  assign write_back_o     = out_q.wb;
  assign mapped_in_o      = out_q.mapped;
  assign frame_o          = out_q.frame;
  assign new_protection_o = out_q.prot;

endmodule
